[hdl/u2a_pkg.sv]
// Shared types, constants and helpers for the unsigned-to-ASCII radix unit.
package u2a_pkg;

   localparam int DIGIT_SLOTS = 32;
   localparam int SLOT_IDX_W  = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
   localparam int SLOT_CNT_W  = $clog2(DIGIT_SLOTS + 1);

   localparam int NUMBER_W = 32;
   localparam int BASE_W   = 5;
   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int CHUNK_W  = 8;
   localparam int CHUNKS   = NUMBER_W / CHUNK_W;
   localparam int CHUNK_CNT_W = $clog2(CHUNKS);

   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
   localparam logic [BASE_W-1:0] BASE_BIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_QUA = BASE_W'(4);
   localparam logic [BASE_W-1:0] BASE_OCT = BASE_W'(8);
   localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_B    = 8'h62;  // 'b'
   localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;  // 'x'

   localparam logic [CHAR_W-1:0] DIGIT_GLYPHS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
   };

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [BASE_W-1:0]   base;
   } u2a_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
      logic              error;
   } u2a_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PREFIX,
      ST_ZERO,
      ST_DIVIDE,
      ST_EMIT
   } u2a_state_type;

   typedef enum logic [1:0] {
      SEL_ERROR,
      SEL_ZERO,
      SEL_PREFIX,
      SEL_DIGIT
   } u2a_sel_type;

   typedef struct packed {
      logic        load;
      logic        div;
      logic        emit;
      u2a_sel_type sel;
      logic        last;
   } u2a_cmd_type;

   typedef struct packed {
      logic base_bad;
      logic base_pfx;
      logic value_zero;
      logic conv_done;
      logic stack_one;
   } u2a_status_type;

endpackage

[hdl/u2a_ctrl.sv]
// Sequencing state machine: prefix, digit extraction and character output.
module u2a_ctrl
   import u2a_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  u2a_status_type status,
   output u2a_cmd_type    cmd
);

   u2a_state_type state_ff;
   u2a_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.base_bad) state_in = ST_IDLE;
            else if (status.base_pfx)     state_in = ST_PREFIX;
            else if (status.value_zero)   state_in = ST_IDLE;
            else                          state_in = ST_DIVIDE;
         end
         ST_PREFIX: begin
            state_in = status.value_zero ? ST_ZERO : ST_DIVIDE;
         end
         ST_ZERO: begin
            state_in = ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.stack_one) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '{load: 1'b0, div: 1'b0, emit: 1'b0, sel: SEL_ZERO, last: 1'b0};
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_CHECK: begin
            priority if (status.base_bad) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_ERROR;
               cmd.last = 1'b1;
            end else if (status.base_pfx) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_ZERO;
            end else if (status.value_zero) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_ZERO;
               cmd.last = 1'b1;
            end else begin
               cmd.emit = 1'b0;
            end
         end
         ST_PREFIX: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_PREFIX;
         end
         ST_ZERO: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_ZERO;
            cmd.last = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_DIGIT;
            cmd.last = status.stack_one;
         end
         default: ;
      endcase
   end

endmodule

[hdl/u2a_datapath.sv]
// Datapath: operand registers, chunked divider, digit stack and output register.
module u2a_datapath
   import u2a_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  u2a_req_type    req_data,
   input  u2a_cmd_type    cmd,
   output u2a_status_type status,
   output logic           rsp_valid,
   output u2a_rsp_type    rsp_data
);

   logic [NUMBER_W-1:0]    work_ff,  work_in;
   logic [BASE_W-1:0]      base_ff,  base_in;
   logic [DIGIT_W-1:0]     rem_ff,   rem_in;
   logic [CHUNK_CNT_W-1:0] chunk_ff, chunk_in;
   logic [SLOT_CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [DIGIT_W-1:0]     digits_ff [DIGIT_SLOTS];
   logic                   rsp_valid_ff, rsp_valid_in;
   u2a_rsp_type            rsp_ff,   rsp_in;

   logic                  is_pow2;
   logic [4:0]            part_rem;
   logic [CHUNK_W-1:0]    quot_byte;
   logic [CHUNK_W-1:0]    in_byte;
   logic [NUMBER_W-1:0]   step_value;
   logic [DIGIT_W-1:0]    step_digit;
   logic                  step_push;
   logic                  pop;
   logic [SLOT_IDX_W-1:0] push_idx;
   logic [SLOT_IDX_W-1:0] top_idx;
   logic [SLOT_CNT_W-1:0] cnt_plus;
   logic [SLOT_CNT_W-1:0] cnt_minus;

   assign is_pow2 = (base_ff == BASE_BIN) || (base_ff == BASE_QUA) ||
                    (base_ff == BASE_OCT) || (base_ff == BASE_HEX);

   // Restoring division of one byte of the dividend per cycle; the partial
   // remainder stays below the base, so five bits suffice.
   always_comb begin
      in_byte   = work_ff[NUMBER_W-1 -: CHUNK_W];
      part_rem  = (chunk_ff == '0) ? 5'd0 : {1'b0, rem_ff};
      quot_byte = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         part_rem = {part_rem[3:0], in_byte[i]};
         if (part_rem >= base_ff) begin
            part_rem     = part_rem - base_ff;
            quot_byte[i] = 1'b1;
         end
      end
   end

   always_comb begin
      step_value = work_ff;
      step_digit = part_rem[DIGIT_W-1:0];
      step_push  = 1'b0;
      if (is_pow2) begin
         step_digit = work_ff[DIGIT_W-1:0] & (base_ff[DIGIT_W-1:0] - DIGIT_W'(1));
         step_push  = 1'b1;
         unique case (base_ff)
            BASE_BIN: step_value = work_ff >> 1;
            BASE_QUA: step_value = work_ff >> 2;
            BASE_OCT: step_value = work_ff >> 3;
            default:  step_value = work_ff >> 4;
         endcase
      end else begin
         step_value = {work_ff[NUMBER_W-CHUNK_W-1:0], quot_byte};
         step_push  = (chunk_ff == CHUNK_CNT_W'(CHUNKS - 1));
      end
   end

   assign cnt_plus  = cnt_ff + SLOT_CNT_W'(1);
   assign cnt_minus = cnt_ff - SLOT_CNT_W'(1);
   assign push_idx  = cnt_ff[SLOT_IDX_W-1:0];
   assign top_idx   = cnt_minus[SLOT_IDX_W-1:0];
   assign pop       = cmd.emit && (cmd.sel == SEL_DIGIT);

   always_comb begin
      work_in  = work_ff;
      base_in  = base_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         work_in  = req_data.number;
         base_in  = req_data.base;
         chunk_in = '0;
         cnt_in   = '0;
      end else if (cmd.div) begin
         work_in = step_value;
         if (!is_pow2) begin
            rem_in   = part_rem[DIGIT_W-1:0];
            chunk_in = chunk_ff + CHUNK_CNT_W'(1);
         end
         if (step_push) cnt_in = cnt_plus;
      end else if (pop) begin
         cnt_in = cnt_minus;
      end
   end

   assign status.base_bad   = (base_ff < BASE_MIN) || (base_ff > BASE_MAX);
   assign status.base_pfx   = (base_ff == BASE_BIN) || (base_ff == BASE_HEX);
   assign status.value_zero = (work_ff == '0);
   assign status.conv_done  = cmd.div && step_push &&
                              ((step_value == '0) ||
                               (cnt_plus == SLOT_CNT_W'(DIGIT_SLOTS)));
   assign status.stack_one  = (cnt_ff == SLOT_CNT_W'(1));

   always_comb begin
      rsp_valid_in = cmd.emit;
      rsp_in.last  = cmd.last;
      rsp_in.error = (cmd.sel == SEL_ERROR);
      unique case (cmd.sel)
         SEL_ERROR:  rsp_in.char_code = CHAR_NUL;
         SEL_ZERO:   rsp_in.char_code = CHAR_ZERO;
         SEL_PREFIX: rsp_in.char_code = (base_ff == BASE_BIN) ? CHAR_B : CHAR_X;
         SEL_DIGIT:  rsp_in.char_code = DIGIT_GLYPHS[digits_ff[top_idx]];
         default:    rsp_in.char_code = CHAR_NUL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      base_ff <= base_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
      if (cmd.div && step_push) digits_ff[push_idx] <= step_digit;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/unsigned_to_ascii_radix_unit.sv]
// Top level of the unsigned-to-ASCII radix unit: controller plus datapath.
// A word is taken on req_data when start is high and busy is low. The unit
// then prints req_data.number in req_data.base as ASCII, most significant
// digit first, one character per rsp_valid strobe; rsp_data.last marks the
// final character. Bases 2 and 16 get a "0b" / "0x" prefix. A base outside
// 2..16 gives a single strobe with error set, last set and char_code zero.
// A prefix, a lone zero or an error word is strobed through the output
// register once the controller has checked base and value; digits follow
// only once extraction has finished. Digits are extracted least significant
// first into a stack and output from its top, one per cycle. For bases 2,
// 4, 8 and 16 each digit comes from a single shift; for other bases the
// divider consumes one byte of the dividend a cycle and pushes a digit once
// all four bytes have passed. busy drops in the cycle the last character is
// strobed, so a new word may be taken then.
// Synchronous reset returns the controller to idle and drops rsp_valid.
// The receiver cannot hold off results; each is shown for one cycle only.
module unsigned_to_ascii_radix_unit
   import u2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  u2a_req_type req_data,
   output logic        rsp_valid,
   output u2a_rsp_type rsp_data
);

   u2a_cmd_type    cmd;
   u2a_status_type status;

   u2a_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   u2a_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/u2a_checker.sv]
// Port-level checks for the unsigned-to-ASCII radix unit, bound to the top.
module u2a_checker
   import u2a_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input u2a_rsp_type rsp_data
);

   // an error word stands alone and carries no text
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.last && (rsp_data.char_code == CHAR_NUL))
      else $error("error word without last or with text");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // no character is strobed straight after the last character
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("character strobed straight after last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("unit idle while a conversion is still printing");

endmodule

bind unsigned_to_ascii_radix_unit u2a_checker u_u2a_checker (.*);
